FILE: sv/rpn_pkg.sv
// Shared types and constants for the RPN stack calculator.
// Holds the item structs, operation and status codes, and the ALU request type.
// No dependencies.
package rpn_pkg;

  // Operation codes carried by each input item.
  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_MOD  = 3'd4,
    OP_POW  = 3'd5,
    OP_DIV  = 3'd6,
    OP_EMIT = 3'd7
  } op_e;

  // Status codes carried by each result item.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_e;

  // Answer pushed for a division or modulo by zero.
  localparam logic [31:0] DIV_ZERO_ANSWER = 32'd2000000000;

  // Input item.
  typedef struct packed {
    op_e                operation;
    logic signed [31:0] operand_value;
  } in_t;

  // Result item.
  typedef struct packed {
    logic signed [31:0] result_value;
    status_e            status;
  } out_t;

  // Request from the stack controller to the arithmetic unit.
  typedef struct packed {
    logic start;
    op_e  op;
  } alu_req_t;

endpackage

FILE: sv/rpn_mem.sv
// Stack storage: one write port and one read port with registered read data.
// Contents are undefined until written; there is no reset on the array.
// Depends on nothing.
module rpn_mem #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [31:0]   wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [31:0]   rd_data_o
);

  logic [31:0] mem_q [DEPTH];
  logic [31:0] rd_data_q;

  // Synchronous write.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Synchronous read into a registered output.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: sv/rpn_alu.sv
// Multi-cycle arithmetic unit: add, sub, mul, truncating div/mod, and pow.
// Division is restoring, one quotient bit per cycle; pow is square-and-multiply
// on one shared 32x32 multiplier. Depends on rpn_pkg.
module rpn_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rpn_pkg::alu_req_t req_i,
  input  logic [31:0]       a_i,
  input  logic [31:0]       b_i,
  output logic              done_o,
  output logic [31:0]       result_o
);

  localparam logic [2:0] A_IDLE    = 3'd0;
  localparam logic [2:0] A_DIV     = 3'd1;
  localparam logic [2:0] A_DIV_FIX = 3'd2;
  localparam logic [2:0] A_POW_M   = 3'd3;
  localparam logic [2:0] A_POW_S   = 3'd4;
  localparam logic [2:0] A_DONE    = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [31:0] res_q, res_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        mod_q, mod_d;
  logic        qneg_q, qneg_d;
  logic        rneg_q, rneg_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] base_q, base_d;
  logic [30:0] exp_q, exp_d;

  logic [31:0] mul_x, mul_y, mul_p;
  logic [31:0] a_mag, b_mag;
  logic [32:0] shifted, diff;

  // Shared multiplier: operands come from the pow registers while raising.
  always_comb begin
    unique case (state_q)
      A_POW_M: begin
        mul_x = acc_q;
        mul_y = base_q;
      end
      A_POW_S: begin
        mul_x = base_q;
        mul_y = base_q;
      end
      default: begin
        mul_x = a_i;
        mul_y = b_i;
      end
    endcase
  end

  assign mul_p = mul_x * mul_y;

  // Operand magnitudes for the divider.
  assign a_mag = a_i[31] ? (32'd0 - a_i) : a_i;
  assign b_mag = b_i[31] ? (32'd0 - b_i) : b_i;

  // One restoring division step.
  assign shifted = {rem_q, quo_q[31]};
  assign diff    = shifted - {1'b0, dvs_q};

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    mod_d   = mod_q;
    qneg_d  = qneg_q;
    rneg_d  = rneg_q;
    acc_d   = acc_q;
    base_d  = base_q;
    exp_d   = exp_q;
    unique case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          unique case (req_i.op)
            rpn_pkg::OP_ADD: begin
              res_d   = a_i + b_i;
              state_d = A_DONE;
            end
            rpn_pkg::OP_SUB: begin
              res_d   = a_i - b_i;
              state_d = A_DONE;
            end
            rpn_pkg::OP_MUL: begin
              res_d   = mul_p;
              state_d = A_DONE;
            end
            rpn_pkg::OP_MOD, rpn_pkg::OP_DIV: begin
              if (b_i == 32'd0) begin
                res_d   = rpn_pkg::DIV_ZERO_ANSWER;
                state_d = A_DONE;
              end else begin
                quo_d   = a_mag;
                rem_d   = 32'd0;
                dvs_d   = b_mag;
                cnt_d   = 5'd0;
                mod_d   = (req_i.op == rpn_pkg::OP_MOD);
                qneg_d  = a_i[31] ^ b_i[31];
                rneg_d  = a_i[31];
                state_d = A_DIV;
              end
            end
            rpn_pkg::OP_POW: begin
              // A zero or negative exponent gives one.
              if (b_i[31] || (b_i == 32'd0)) begin
                res_d   = 32'd1;
                state_d = A_DONE;
              end else begin
                acc_d   = 32'd1;
                base_d  = a_i;
                exp_d   = b_i[30:0];
                state_d = A_POW_M;
              end
            end
            default: begin
              res_d   = 32'd0;
              state_d = A_DONE;
            end
          endcase
        end
      end
      A_DIV: begin
        if (!diff[32]) begin
          rem_d = diff[31:0];
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = shifted[31:0];
          quo_d = {quo_q[30:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          state_d = A_DIV_FIX;
        end
      end
      A_DIV_FIX: begin
        // Remainder takes the sign of a; quotient truncates toward zero.
        if (mod_q) begin
          res_d = rneg_q ? (32'd0 - rem_q) : rem_q;
        end else begin
          res_d = qneg_q ? (32'd0 - quo_q) : quo_q;
        end
        state_d = A_DONE;
      end
      A_POW_M: begin
        if (exp_q[0]) begin
          acc_d = mul_p;
        end
        state_d = A_POW_S;
      end
      A_POW_S: begin
        base_d = mul_p;
        exp_d  = {1'b0, exp_q[30:1]};
        if (exp_q[30:1] == 30'd0) begin
          res_d   = acc_q;
          state_d = A_DONE;
        end else begin
          state_d = A_POW_M;
        end
      end
      A_DONE: begin
        state_d = A_IDLE;
      end
      default: begin
        state_d = A_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    cnt_q  <= cnt_d;
    mod_q  <= mod_d;
    qneg_q <= qneg_d;
    rneg_q <= rneg_d;
    acc_q  <= acc_d;
    base_q <= base_d;
    exp_q  <= exp_d;
  end

  assign done_o   = (state_q == A_DONE);
  assign result_o = res_q;

endmodule

FILE: sv/rpn_stack_calculator_unit.sv
// RPN stack calculator top level: stack controller, stack memory and ALU.
// Steps: a push writes the top entry; an emit reads it out to the output register;
// arithmetic reads a, then b, runs the ALU and writes back; pow multiplies and squares per exponent bit.
// One item at a time; the memory's single read port reads a and b in turn.
// Reset clears the depth count and handshake state; stack contents stay undefined.
// Depends on rpn_pkg, rpn_mem and rpn_alu.
module rpn_stack_calculator_unit #(
  parameter int unsigned STACK_DEPTH = 128
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rpn_pkg::in_t  in_item_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rpn_pkg::out_t out_item_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RDA    = 3'd1;
  localparam logic [2:0] S_RDB    = 3'd2;
  localparam logic [2:0] S_EXEC   = 3'd3;
  localparam logic [2:0] S_REPORT = 3'd4;

  logic [2:0]     state_q, state_d;
  logic [DW-1:0]  depth_q, depth_d;
  rpn_pkg::op_e   op_q, op_d;
  logic [31:0]    a_q, a_d;
  rpn_pkg::out_t  rep_q, rep_d;
  logic           out_valid_q, out_valid_d;
  rpn_pkg::out_t  out_q, out_d;

  logic [DW-1:0]  dm1, dm2;
  logic           wr_en, rd_en;
  logic [AW-1:0]  wr_addr, rd_addr;
  logic [31:0]    wr_data, rd_data;

  rpn_pkg::alu_req_t alu_req;
  logic              alu_done;
  logic [31:0]       alu_result;

  assign dm1 = depth_q - DW'(1);
  assign dm2 = depth_q - DW'(2);

  assign in_ready_o = (state_q == S_IDLE);

  // Stack controller.
  always_comb begin
    state_d       = state_q;
    depth_d       = depth_q;
    op_d          = op_q;
    a_d           = a_q;
    rep_d         = rep_q;
    out_valid_d   = out_valid_q;
    out_d         = out_q;
    wr_en         = 1'b0;
    wr_addr       = depth_q[AW-1:0];
    wr_data       = in_item_i.operand_value;
    rd_en         = 1'b0;
    rd_addr       = dm1[AW-1:0];
    alu_req.start = 1'b0;
    alu_req.op    = op_q;

    // A waiting result leaves when taken.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d = in_item_i.operation;
          unique case (in_item_i.operation)
            rpn_pkg::OP_PUSH: begin
              if (depth_q == DW'(STACK_DEPTH)) begin
                rep_d.result_value = '0;
                rep_d.status       = rpn_pkg::ST_OVER;
                state_d            = S_REPORT;
              end else begin
                wr_en   = 1'b1;
                depth_d = depth_q + DW'(1);
              end
            end
            rpn_pkg::OP_EMIT: begin
              if (depth_q == DW'(0)) begin
                rep_d.result_value = '0;
                rep_d.status       = rpn_pkg::ST_UNDER;
                state_d            = S_REPORT;
              end else begin
                rd_en   = 1'b1;
                depth_d = dm1;
                state_d = S_RDA;
              end
            end
            default: begin
              if (depth_q < DW'(2)) begin
                rep_d.result_value = '0;
                rep_d.status       = rpn_pkg::ST_UNDER;
                state_d            = S_REPORT;
              end else begin
                rd_en   = 1'b1;
                state_d = S_RDA;
              end
            end
          endcase
        end
      end
      S_RDA: begin
        if (op_q == rpn_pkg::OP_EMIT) begin
          rep_d.result_value = rd_data;
          rep_d.status       = rpn_pkg::ST_OK;
          state_d            = S_REPORT;
        end else begin
          // Top is a; fetch b from the entry below it.
          a_d     = rd_data;
          rd_en   = 1'b1;
          rd_addr = dm2[AW-1:0];
          state_d = S_RDB;
        end
      end
      S_RDB: begin
        alu_req.start = 1'b1;
        state_d       = S_EXEC;
      end
      S_EXEC: begin
        if (alu_done) begin
          wr_en   = 1'b1;
          wr_addr = dm2[AW-1:0];
          wr_data = alu_result;
          depth_d = dm1;
          state_d = S_IDLE;
        end
      end
      S_REPORT: begin
        if (!out_valid_q) begin
          out_valid_d = 1'b1;
          out_d       = rep_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      depth_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    a_q   <= a_d;
    rep_q <= rep_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Stack memory.
  rpn_mem #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Arithmetic unit; b arrives straight from the memory read port.
  rpn_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .a_i      (a_q),
    .b_i      (rd_data),
    .done_o   (alu_done),
    .result_o (alu_result)
  );

  // The depth count never passes the stack size.
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  // The ALU only finishes while the controller waits for it.
  a_alu_done_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> (state_q == S_EXEC))
    else $error("ALU finished outside execute");

  // A completed arithmetic operation removes exactly one entry.
  a_exec_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && alu_done) |=> (depth_q == $past(depth_q) - DW'(1)))
    else $error("arithmetic write-back did not pop one entry");

  // Error results carry a zero value.
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status != rpn_pkg::ST_OK)
      |-> (out_item_o.result_value == 32'sd0))
    else $error("error result with nonzero value");

endmodule

FILE: test/rpn_checker.sv
`timescale 1ns / 100ps
// Checker for the RPN stack calculator: watches both item channels, keeps its own
// copy of the stack, predicts each result item and compares it with what comes out.
// Depends on rpn_pkg for the item structs, codes and the division-by-zero answer.
module rpn_checker
  import rpn_pkg::*;
#(
  parameter int unsigned DEPTH = 128
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_item_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_item_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   item_count_o,
  output int   result_count_o,
  output int   under_count_o,
  output int   over_count_o
);

  // Shadow stack and the answers still owed by the block, oldest first.
  logic [31:0] calc_stack [DEPTH];
  int unsigned calc_depth;
  out_t        owed_answers [$];

  // Power by square and multiply, wrapped to 32 bits; a negative exponent gives 1.
  function automatic logic [31:0] wrap_power(logic [31:0] base, logic [31:0] expo);
    logic [31:0] acc;
    acc = 32'd1;
    if (expo[31]) return acc;
    for (int i = 0; i < 31; i++) begin
      if (expo[i]) acc = acc * base;
      base = base * base;
    end
    return acc;
  endfunction

  // Truncating signed division or remainder, done in 64 bits so that the most
  // negative value over minus one wraps instead of trapping.
  function automatic logic [31:0] trunc_divide(logic [31:0] num, logic [31:0] den,
                                               logic want_rem);
    longint sn, sd, quo, rem;
    if (den == '0) return DIV_ZERO_ANSWER;
    sn  = {{32{num[31]}}, num};
    sd  = {{32{den[31]}}, den};
    quo = sn / sd;
    rem = sn - quo * sd;
    return want_rem ? rem[31:0] : quo[31:0];
  endfunction

  // Apply one accepted operation to the shadow stack and queue any result it owes.
  task automatic evaluate_op(input in_t item);
    logic [31:0] a, b, r;
    out_t        ans;
    item_count_o++;
    ans.result_value = '0;
    ans.status       = ST_OK;
    case (item.operation)
      OP_PUSH: begin
        if (calc_depth >= DEPTH) begin
          ans.status = ST_OVER;
          owed_answers.push_back(ans);
        end else begin
          calc_stack[calc_depth] = item.operand_value;
          calc_depth++;
        end
      end
      OP_EMIT: begin
        if (calc_depth == 0) begin
          ans.status = ST_UNDER;
        end else begin
          calc_depth--;
          ans.result_value = calc_stack[calc_depth];
        end
        owed_answers.push_back(ans);
      end
      default: begin
        if (calc_depth < 2) begin
          ans.status = ST_UNDER;
          owed_answers.push_back(ans);
        end else begin
          // The top is a, the entry below it is b; the answer is a op b.
          a = calc_stack[calc_depth - 1];
          b = calc_stack[calc_depth - 2];
          case (item.operation)
            OP_ADD:  r = a + b;
            OP_SUB:  r = a - b;
            OP_MUL:  r = a * b;
            OP_MOD:  r = trunc_divide(a, b, 1'b1);
            OP_POW:  r = wrap_power(a, b);
            default: r = trunc_divide(a, b, 1'b0);
          endcase
          calc_depth--;
          calc_stack[calc_depth - 1] = r;
        end
      end
    endcase
    if (ans.status == ST_UNDER) under_count_o++;
    if (ans.status == ST_OVER) over_count_o++;
  endtask

  // Compare one result item with the oldest answer owed.
  task automatic compare_answer(input out_t got);
    out_t want;
    result_count_o++;
    if (owed_answers.size() == 0) begin
      if (fail_count_o < 10)
        $display("%0t: result %0d arrived with none owed: value %0d status %0d",
                 $realtime, result_count_o, got.result_value, got.status);
      fail_count_o++;
    end else begin
      want = owed_answers.pop_front();
      if (got.result_value !== want.result_value || got.status !== want.status) begin
        if (fail_count_o < 10)
          $display("%0t: result %0d: value exp %0d got %0d, status exp %0d got %0d",
                   $realtime, result_count_o, want.result_value, got.result_value,
                   want.status, got.status);
        fail_count_o++;
      end
    end
  endtask

  // Results are taken before inputs: a result leaving at the same edge as an
  // item enters always belongs to an earlier item.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calc_depth = 0;
      owed_answers.delete();
      fail_count_o   = 0;
      item_count_o   = 0;
      result_count_o = 0;
      under_count_o  = 0;
      over_count_o   = 0;
    end else begin
      if (out_valid_i && out_ready_i) compare_answer(out_item_i);
      if (in_valid_i && in_ready_i) evaluate_op(in_item_i);
    end
    pending_o = owed_answers.size();
  end

endmodule

FILE: test/rpn_stack_calculator_unit_test.sv
`timescale 1ns / 100ps
// Top of the RPN stack calculator testbench: clock, reset, item stimulus and
// receiver stalls. Instantiates the block and rpn_checker, and gives the verdict.
// Depends on rpn_pkg, rpn_checker and rpn_stack_calculator_unit.
module rpn_stack_calculator_unit_test;
  import rpn_pkg::*;

  localparam int unsigned DEPTH        = 128;
  localparam int          RANDOM_ITEMS = 1075;
  localparam logic [31:0] MOST_NEG     = 32'h8000_0000;
  localparam logic [31:0] MOST_POS     = 32'h7FFF_FFFF;

  // Operation mixes for the random part.
  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EXPR
  } mix_e;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    RDY_FREE,
    RDY_RANDOM,
    RDY_PERIODIC
  } rdy_mode_e;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_item_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_item_o;

  int fail_count, pending, item_count, result_count, under_count, over_count;
  int stim_depth;  // Stack depth as seen by the stimulus, used only for steering.
  int burst_left;

  rpn_stack_calculator_unit #(
    .STACK_DEPTH(DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  rpn_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_item_i     (in_item_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_item_i    (out_item_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .item_count_o  (item_count),
    .result_count_o(result_count),
    .under_count_o (under_count),
    .over_count_o  (over_count)
  );

  // Clock with a 4 ns period.
  always #2 clk_i = ~clk_i;

  // Operand values lean on the extremes and on small numbers, so that zero
  // divisors, short exponents and wraparound come up often.
  function automatic logic [31:0] next_operand();
    case ($urandom_range(0, 9))
      0:       return MOST_NEG;
      1:       return MOST_POS;
      2:       return '0;
      3:       return '1;
      4:       return 32'd1;
      5, 6:    return $urandom_range(0, 32) - 16;
      7:       return $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // Choose the next operation for a mix; a small share is pure noise.
  function automatic op_e pick_op(mix_e mix, int depth);
    int roll;
    op_e arith;
    roll  = $urandom_range(0, 99);
    arith = op_e'(3'($urandom_range(1, 6)));
    if (roll < 8) return op_e'(3'($urandom_range(0, 7)));
    case (mix)
      MIX_FILL:  return (roll < 90) ? OP_PUSH : arith;
      MIX_DRAIN: return (roll < 35) ? OP_EMIT : (roll < 90) ? arith : OP_PUSH;
      default: begin
        // Keep a shallow, well-formed expression going.
        if (depth < 2) return (roll < 90) ? OP_PUSH : OP_EMIT;
        if (depth > 12) return (roll < 70) ? arith : OP_EMIT;
        return (roll < 45) ? OP_PUSH : (roll < 85) ? arith : OP_EMIT;
      end
    endcase
  endfunction

  // Offer one item, with a random gap at the start of each burst. Called and
  // left at a falling edge.
  task automatic send_item(input op_e op, input logic [31:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        in_item_i  <= '{operation: op, operand_value: $urandom};
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_item_i  <= '{operation: op, operand_value: value};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    case (op)
      OP_PUSH: if (stim_depth < DEPTH) stim_depth++;
      OP_EMIT: if (stim_depth > 0) stim_depth--;
      default: if (stim_depth >= 2) stim_depth--;
    endcase
    @(negedge clk_i);
  endtask

  // Reset, directed items, random items, drain and verdict.
  initial begin : stimulus
    mix_e mix;
    int   seg, seg_len, sent;
    clk_i      = 1'b0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    burst_left = 0;
    stim_depth = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Underflow on an empty stack and with a single entry, then division by zero.
    send_item(OP_EMIT, $urandom);
    send_item(OP_ADD, $urandom);
    send_item(OP_PUSH, '0);
    send_item(OP_SUB, $urandom);
    send_item(OP_PUSH, 32'd7);
    send_item(OP_DIV, $urandom);
    // Modulo by zero.
    send_item(OP_PUSH, '0);
    send_item(OP_PUSH, -32'sd9);
    send_item(OP_MOD, $urandom);
    // Most negative over minus one: quotient wraps, remainder is zero.
    send_item(OP_PUSH, '1);
    send_item(OP_PUSH, MOST_NEG);
    send_item(OP_DIV, $urandom);
    send_item(OP_PUSH, '1);
    send_item(OP_PUSH, MOST_NEG);
    send_item(OP_MOD, $urandom);
    // Negative exponent, then a zero exponent.
    send_item(OP_POW, $urandom);
    send_item(OP_PUSH, '0);
    send_item(OP_PUSH, MOST_POS);
    send_item(OP_POW, $urandom);
    // Wraparound in add, sub and mul.
    send_item(OP_PUSH, MOST_POS);
    send_item(OP_ADD, $urandom);
    send_item(OP_SUB, $urandom);
    send_item(OP_MUL, $urandom);
    // The remainder takes the sign of the top entry.
    send_item(OP_PUSH, 32'd3);
    send_item(OP_PUSH, -32'sd7);
    send_item(OP_MOD, $urandom);
    send_item(OP_EMIT, $urandom);

    // Random part in segments: fill to overflow first, drain to underflow next,
    // then mostly well-formed expressions mixed with the other two.
    seg  = 0;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case (seg)
        0: begin
          mix     = MIX_FILL;
          seg_len = 180;
        end
        1: begin
          mix     = MIX_DRAIN;
          seg_len = 200;
        end
        default: begin
          mix     = ($urandom_range(0, 3) == 0) ? mix_e'(2'($urandom_range(0, 1))) : MIX_EXPR;
          seg_len = $urandom_range(30, 150);
        end
      endcase
      seg++;
      for (int k = 0; k < seg_len && sent < RANDOM_ITEMS; k++) begin
        send_item(pick_op(mix, stim_depth), next_operand());
        sent++;
      end
    end
    in_valid_i <= 1'b0;

    // Wait for every owed result, then long enough to catch a stray one.
    while (pending != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);

    $display("Covered %0d items over %0d segments; %0d results, %0d underflows, %0d overflows.",
             item_count, seg, result_count, under_count, over_count);
    $display("Mismatches: %0d.", fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Receiver: stall patterns in random segments, plus two long hold-offs so the
  // block backs up and stalls its input.
  initial begin : receiver
    rdy_mode_e mode;
    int cycles, seg_left, period, stall_len, duty;
    out_ready_i = 1'b0;
    cycles      = 0;
    seg_left    = 0;
    mode        = RDY_FREE;
    period      = 2;
    stall_len   = 1;
    duty        = 50;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      cycles++;
      if (cycles == 3000 || cycles == 30000) begin
        out_ready_i <= 1'b0;
        repeat (600) @(negedge clk_i);
      end else begin
        if (seg_left == 0) begin
          mode      = rdy_mode_e'(2'($urandom_range(0, 2)));
          seg_left  = $urandom_range(20, 200);
          period    = $urandom_range(2, 24);
          stall_len = $urandom_range(1, period - 1);
          duty      = $urandom_range(20, 90);
        end
        seg_left--;
        case (mode)
          RDY_FREE:   out_ready_i <= 1'b1;
          RDY_RANDOM: out_ready_i <= ($urandom_range(0, 99) < duty);
          default:    out_ready_i <= ((cycles % period) >= stall_len);
        endcase
      end
    end
  end

  // Run limit, several times the slowest correct run.
  initial begin : watchdog
    #3_000_000;
    $display("Timeout: the run did not complete.");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
